// File: sv/bcip_pkg.sv
// Shared types and constants for the braced integer frame parser.
// No dependencies; imported by bcip_byte_step and the top level.
`default_nettype none

package bcip_pkg;

	// frame geometry and value range
	localparam int NUM_FIELDS  = 4;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(NUM_FIELDS + 1);
	localparam int MAG_W       = VALUE_WIDTH;
	localparam int PROD_W      = MAG_W + 4;
	localparam int OUT_SLOTS   = 4;
	localparam int OUT_W       = 32;
	localparam int APPLIED_W   = 3;

	// framing characters
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} num_phase_t;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [MAG_W-1:0]              mag_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [NUM_FIELDS-1:0][VALUE_WIDTH-1:0] field_vals_t;

	// parser control state, cleared by reset and after every buffer
	typedef struct packed {
		logic       in_frame;
		cnt_t       field_index;
		logic       after_sep;
		num_phase_t phase;
		logic       negative;
		mag_t       mag;
		cnt_t       complete_count;
		logic       complete_seen;
	} parse_ctrl_t;

	// field values of the open frame and of the last complete frame
	typedef struct packed {
		field_vals_t open_vals;
		field_vals_t complete_vals;
	} frame_vals_t;

	localparam mag_t MAG_CAP = mag_t'(1) << (VALUE_WIDTH - 1);

	localparam parse_ctrl_t CTRL_IDLE = '{
		in_frame:       1'b0,
		field_index:    '0,
		after_sep:      1'b1,
		phase:          PH_SKIP,
		negative:       1'b0,
		mag:            '0,
		complete_count: '0,
		complete_seen:  1'b0
	};

endpackage

`default_nettype wire

// File: sv/bcip_byte_step.sv
// Next-state function of the frame parser for one received character.
// Depends on bcip_pkg; instantiated by braced_csv_integer_frame_parser_top.
`default_nettype none

module bcip_byte_step
	import bcip_pkg::*;
(
	input  wire logic [7:0]  data_byte,
	input  wire parse_ctrl_t ctrl,
	input  wire frame_vals_t vals,
	output parse_ctrl_t      ctrl_nxt,
	output frame_vals_t      vals_nxt
);

	logic                is_digit;
	logic                is_space;
	logic [3:0]          digit;
	logic [PROD_W-1:0]   prod;
	mag_t                mag_acc;
	value_t              field_val;

	// character classes
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_space = (data_byte == CH_SPACE) ||
		((data_byte >= CH_TAB) && (data_byte <= CH_CR));
	assign digit    = 4'(data_byte - CH_ZERO);

	// decimal accumulate, saturating at the magnitude cap
	assign prod    = (PROD_W'(ctrl.mag) << 3) + (PROD_W'(ctrl.mag) << 1) + PROD_W'(digit);
	assign mag_acc = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : mag_t'(prod);

	// saturated signed value of the field being closed
	always_comb begin
		if (ctrl.negative) begin
			field_val = -value_t'(ctrl.mag);
		end else if (ctrl.mag[MAG_W-1]) begin
			field_val = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else begin
			field_val = value_t'(ctrl.mag);
		end
	end

	// per-character state update
	always_comb begin
		ctrl_nxt = ctrl;
		vals_nxt = vals;
		if (data_byte == CH_OPEN) begin
			ctrl_nxt.in_frame    = 1'b1;
			ctrl_nxt.field_index = '0;
			ctrl_nxt.after_sep   = 1'b1;
			ctrl_nxt.phase       = PH_SKIP;
			ctrl_nxt.negative    = 1'b0;
			ctrl_nxt.mag         = '0;
		end else if (!ctrl.in_frame) begin
			ctrl_nxt = ctrl;
		end else if ((data_byte == CH_CLOSE) || (data_byte == CH_COMMA)) begin
			// close the current field unless the frame ends right after its opening brace or a comma
			if ((data_byte == CH_COMMA) || !ctrl.after_sep) begin
				if (ctrl.field_index < cnt_t'(NUM_FIELDS)) begin
					for (int j = 0; j < NUM_FIELDS; j++) begin
						if (ctrl.field_index == cnt_t'(j)) begin
							vals_nxt.open_vals[j] = field_val;
						end
					end
					ctrl_nxt.field_index = ctrl.field_index + cnt_t'(1);
				end
			end
			ctrl_nxt.phase    = PH_SKIP;
			ctrl_nxt.negative = 1'b0;
			ctrl_nxt.mag      = '0;
			if (data_byte == CH_CLOSE) begin
				vals_nxt.complete_vals  = vals_nxt.open_vals;
				ctrl_nxt.complete_count = ctrl_nxt.field_index;
				ctrl_nxt.complete_seen  = 1'b1;
				ctrl_nxt.in_frame       = 1'b0;
			end else begin
				ctrl_nxt.after_sep = 1'b1;
			end
		end else begin
			ctrl_nxt.after_sep = 1'b0;
			case (ctrl.phase)
				PH_SKIP: begin
					if (is_space) begin
						ctrl_nxt.phase = PH_SKIP;
					end else if (data_byte == CH_PLUS) begin
						ctrl_nxt.phase = PH_DIGITS;
					end else if (data_byte == CH_MINUS) begin
						ctrl_nxt.negative = 1'b1;
						ctrl_nxt.phase    = PH_DIGITS;
					end else if (is_digit) begin
						ctrl_nxt.mag   = mag_t'(digit);
						ctrl_nxt.phase = PH_DIGITS;
					end else begin
						ctrl_nxt.phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						ctrl_nxt.mag = mag_acc;
					end else begin
						ctrl_nxt.phase = PH_DONE;
					end
				end
				default: begin
					ctrl_nxt.phase = ctrl.phase;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/braced_csv_integer_frame_parser_top.sv
// Top level of the braced integer frame parser: input stage, parser state,
// stored values and result register. Depends on bcip_pkg and bcip_byte_step.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one character per beat in
//   data_byte; buffer_end marks the last character of a received buffer.
//   Frames look like {a,b,c,d}; each field is read as a decimal integer and
//   saturated to the signed 32-bit range. Only the last complete frame of a
//   buffer is applied, and only as many stored values as it has fields.
//   The output channel (out_valid/out_ready) carries one beat per buffer:
//   the four stored values, frame_found and fields_applied.
//   Throughput is one character per cycle while in_ready is high; the parser state updates once per
//   character through a single step of combinational logic.
//   A buffer_end beat passes the input register, then the result register.
//   When the receiver stalls, characters keep flowing until a second
//   buffer_end beat reaches the input register while a result is still
//   pending; only then does in_ready drop.
//   Reset clears the parser state, the stored values and both valid flags.
`default_nettype none

module braced_csv_integer_frame_parser_top
	import bcip_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [7:0]               data_byte,
	input  wire logic                     buffer_end,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [OUT_W-1:0]       right_encoder,
	output logic signed [OUT_W-1:0]       left_encoder,
	output logic signed [OUT_W-1:0]       lift_position,
	output logic signed [OUT_W-1:0]       claw_position,
	output logic                          frame_found,
	output logic [APPLIED_W-1:0]          fields_applied
);

	logic                              valid_s1;
	logic [7:0]                        byte_s1;
	logic                              end_s1;
	logic                              advance;

	parse_ctrl_t                       ctrl_q;
	parse_ctrl_t                       ctrl_nxt;
	frame_vals_t                       vals_q;
	frame_vals_t                       vals_nxt;
	field_vals_t                       stored_q;
	field_vals_t                       stored_nxt;
	cnt_t                              applied;

	logic                              out_valid_q;
	logic [OUT_SLOTS-1:0][OUT_W-1:0]   out_vals_q;
	logic [OUT_SLOTS-1:0][OUT_W-1:0]   out_vals_nxt;
	logic                              found_q;
	logic [APPLIED_W-1:0]              applied_q;

	// input stage holds back only a buffer end that finds the result register full
	assign advance  = valid_s1 && !(end_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	// parser step for the registered character
	bcip_byte_step u_step (
		.data_byte (byte_s1),
		.ctrl      (ctrl_q),
		.vals      (vals_q),
		.ctrl_nxt  (ctrl_nxt),
		.vals_nxt  (vals_nxt)
	);

	// apply the last complete frame at buffer end
	always_comb begin
		applied    = ctrl_nxt.complete_seen ? ctrl_nxt.complete_count : '0;
		stored_nxt = stored_q;
		for (int k = 0; k < NUM_FIELDS; k++) begin
			if (cnt_t'(k) < applied) begin
				stored_nxt[k] = vals_nxt.complete_vals[k];
			end
		end
		out_vals_nxt = '0;
		for (int k = 0; k < OUT_SLOTS; k++) begin
			if (k < NUM_FIELDS) begin
				out_vals_nxt[k] = OUT_W'(signed'(stored_nxt[k]));
			end
		end
	end

	// parser control and stored values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= CTRL_IDLE;
			stored_q <= '0;
		end else if (advance) begin
			if (end_s1) begin
				ctrl_q   <= CTRL_IDLE;
				stored_q <= stored_nxt;
			end else begin
				ctrl_q <= ctrl_nxt;
			end
		end
	end

	// frame values are only read after they are written
	always_ff @(posedge clk) begin
		if (advance) begin
			vals_q <= vals_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			out_vals_q <= out_vals_nxt;
			found_q    <= ctrl_nxt.complete_seen;
			applied_q  <= APPLIED_W'(applied);
		end
	end

	assign out_valid      = out_valid_q;
	assign right_encoder  = out_vals_q[0];
	assign left_encoder   = out_vals_q[1];
	assign lift_position  = out_vals_q[2];
	assign claw_position  = out_vals_q[3];
	assign frame_found    = found_q;
	assign fields_applied = applied_q;

endmodule

`default_nettype wire
